>>> design/dcf_pkg.sv
package dcf_pkg;

   localparam int COARSE_BITS_DEF = 16;
   localparam int FINE_BITS_DEF   = 8;

   localparam int DELAY_W  = 52;
   localparam int PERIOD_W = 33;
   localparam int QUANT_W  = 36;          // period times divider of at most 8
   localparam int DIV_W    = QUANT_W + 1; // twice the quantum for rounding
   localparam int NUM_W    = DELAY_W + 2; // 2*delay + quantum
   localparam int CSR_W    = PERIOD_W;

   localparam logic [PERIOD_W-1:0] INT_PERIOD_QNS = PERIOD_W'(160);
   localparam logic [PERIOD_W-1:0] MAX_EXT_PERIOD = PERIOD_W'(64'd8000000000);
   localparam logic [DELAY_W-1:0]  DELAY_MAX      = {DELAY_W{1'b1}};

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic [1:0] SRC_EXTERNAL = 2'd0;

   typedef enum logic [1:0] {
      CSR_SPLIT_MODE   = 2'd0,
      CSR_CLOCK_SOURCE = 2'd1,
      CSR_DIV_EXP      = 2'd2,
      CSR_EXT_PERIOD   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic decode;
      logic coarse_only;
      logic rounding;
      logic ovl;
   } ctl_type;

endpackage

>>> design/dcf_if.sv
interface dcf_req_if #(
   parameter int COARSE_BITS = 16,
   parameter int FINE_BITS   = 8
);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [51:0]            delay_in_qns;
   logic [COARSE_BITS-1:0] coarse_in;
   logic [FINE_BITS-1:0]   fine_in;

   modport source (output valid, command, delay_in_qns, coarse_in, fine_in, input ready);
   modport sink   (input valid, command, delay_in_qns, coarse_in, fine_in, output ready);
endinterface

interface dcf_rsp_if #(
   parameter int COARSE_BITS = 16,
   parameter int FINE_BITS   = 8
);
   logic                   valid;
   logic                   ready;
   logic [COARSE_BITS-1:0] coarse_out;
   logic [FINE_BITS-1:0]   fine_out;
   logic [51:0]            delay_out_qns;
   logic                   overload;

   modport source (output valid, coarse_out, fine_out, delay_out_qns, overload, input ready);
   modport sink   (input valid, coarse_out, fine_out, delay_out_qns, overload, output ready);
endinterface

>>> design/dcf_cell.sv
module dcf_cell #(
   parameter int COARSE_BITS = 16,
   parameter int FINE_BITS   = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  dcf_pkg::ctl_type            ctl_i,
   input  logic [dcf_pkg::NUM_W-1:0]   num_i,
   input  logic [dcf_pkg::DIV_W-1:0]   dvs_i,
   input  logic [dcf_pkg::DIV_W-1:0]   rem_i,
   input  logic [COARSE_BITS-1:0]      quo_i,
   input  logic                        sat_i,
   input  logic [COARSE_BITS-1:0]      code_c_i,
   input  logic [FINE_BITS-1:0]        code_f_i,
   output dcf_pkg::ctl_type            ctl_o,
   output logic [dcf_pkg::NUM_W-1:0]   num_o,
   output logic [dcf_pkg::DIV_W-1:0]   dvs_o,
   output logic [dcf_pkg::DIV_W-1:0]   rem_o,
   output logic [COARSE_BITS-1:0]      quo_o,
   output logic                        sat_o,
   output logic [COARSE_BITS-1:0]      code_c_o,
   output logic [FINE_BITS-1:0]        code_f_o
);
   import dcf_pkg::*;

   ctl_type                ctl_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [DIV_W-1:0]       dvs_ff, rem_ff, rem_in;
   logic [COARSE_BITS-1:0] quo_ff, code_c_ff;
   logic                   sat_ff;
   logic [FINE_BITS-1:0]   code_f_ff;
   logic [DIV_W:0]         shifted, diff;
   logic                   ge;

   // one restoring division step on the numerator msb
   always_comb begin
      shifted = {rem_i, num_i[NUM_W-1]};
      diff    = shifted - {1'b0, dvs_i};
      ge      = shifted >= {1'b0, dvs_i};
      rem_in  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
   end

   // only the valid bit is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff             <= {num_i[NUM_W-2:0], 1'b0};
         dvs_ff             <= dvs_i;
         rem_ff             <= rem_in;
         quo_ff             <= {quo_i[COARSE_BITS-2:0], ge};
         sat_ff             <= sat_i | quo_i[COARSE_BITS-1];
         code_c_ff          <= code_c_i;
         code_f_ff          <= code_f_i;
      end
   end

   assign ctl_o    = ctl_ff;
   assign num_o    = num_ff;
   assign dvs_o    = dvs_ff;
   assign rem_o    = rem_ff;
   assign quo_o    = quo_ff;
   assign sat_o    = sat_ff;
   assign code_c_o = code_c_ff;
   assign code_f_o = code_f_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid && !ctl_ff.ovl |-> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");

   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      adv && sat_i |=> sat_ff)
      else $error("saturation flag lost in cell");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ctl_ff.valid == $past(ctl_ff.valid))
      else $error("cell valid changed while stalled");

endmodule

>>> design/dcf_tail.sv
module dcf_tail #(
   parameter int COARSE_BITS = 16,
   parameter int FINE_BITS   = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_ready,
   output logic                        adv,
   input  dcf_pkg::ctl_type            ctl_i,
   input  logic [dcf_pkg::DIV_W-1:0]   dvs_i,
   input  logic [dcf_pkg::DIV_W-1:0]   rem_i,
   input  logic [COARSE_BITS-1:0]      quo_i,
   input  logic                        sat_i,
   input  logic [COARSE_BITS-1:0]      code_c_i,
   input  logic [FINE_BITS-1:0]        code_f_i,
   output logic                        out_valid,
   output logic [COARSE_BITS-1:0]      coarse_out,
   output logic [FINE_BITS-1:0]        fine_out,
   output logic [dcf_pkg::DELAY_W-1:0] delay_out,
   output logic                        overload
);
   import dcf_pkg::*;

   localparam int PROD_W = COARSE_BITS + QUANT_W;
   localparam int SUM_W  = (PROD_W + 1 > DELAY_W + 1) ? PROD_W + 1 : DELAY_W + 1;

   logic                   a_valid_ff, b_valid_ff, out_valid_ff;
   logic                   a_ovl_ff, b_ovl_ff, a_conly_ff;
   logic [COARSE_BITS-1:0] a_coarse_ff, a_coarse_in, b_coarse_ff, out_coarse_ff;
   logic [FINE_BITS-1:0]   a_fine_ff, a_fine_in, b_fine_ff, out_fine_ff;
   logic [QUANT_W-1:0]     a_q_ff, a_q_in;
   logic [PROD_W-1:0]      b_prod_ff;
   logic [SUM_W-1:0]       sum;
   logic [DELAY_W-1:0]     out_delay_ff, delay_in;
   logic                   out_ovl_ff;

   assign adv = !out_valid_ff || rsp_ready;

   always_comb begin
      if (ctl_i.decode) begin
         a_coarse_in = code_c_i;
         a_fine_in   = ctl_i.coarse_only ? '0 : code_f_i;
      end else begin
         a_coarse_in = sat_i ? {COARSE_BITS{1'b1}} : quo_i;
         if (ctl_i.coarse_only) begin
            a_fine_in = '0;
         end else if (rem_i > DIV_W'({FINE_BITS{1'b1}})) begin
            a_fine_in = {FINE_BITS{1'b1}};
         end else begin
            a_fine_in = rem_i[FINE_BITS-1:0];
         end
      end
      // rounding items carry twice the quantum as divisor
      a_q_in = ctl_i.rounding ? dvs_i[DIV_W-1:1] : dvs_i[QUANT_W-1:0];
   end

   always_comb begin
      sum      = SUM_W'(b_prod_ff) + SUM_W'(b_fine_ff);
      delay_in = (sum > SUM_W'(DELAY_MAX)) ? DELAY_MAX : sum[DELAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= ctl_i.valid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_coarse_ff   <= a_coarse_in;
         a_fine_ff     <= a_fine_in;
         a_q_ff        <= a_q_in;
         a_ovl_ff      <= ctl_i.ovl;
         a_conly_ff    <= ctl_i.coarse_only;
         b_prod_ff     <= a_coarse_ff * a_q_ff;
         b_coarse_ff   <= a_coarse_ff;
         b_fine_ff     <= a_fine_ff;
         b_ovl_ff      <= a_ovl_ff;
         out_coarse_ff <= b_ovl_ff ? '0 : b_coarse_ff;
         out_fine_ff   <= b_ovl_ff ? '0 : b_fine_ff;
         out_delay_ff  <= b_ovl_ff ? '0 : delay_in;
         out_ovl_ff    <= b_ovl_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign coarse_out = out_coarse_ff;
   assign fine_out   = out_fine_ff;
   assign delay_out  = out_delay_ff;
   assign overload   = out_ovl_ff;

   a_conly_no_fine: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_conly_ff |-> a_fine_ff == '0)
      else $error("fine code set in coarse-only mode");

   a_ovl_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ovl_ff |-> out_coarse_ff == '0 && out_fine_ff == '0
                                     && out_delay_ff == '0)
      else $error("overload item carries nonzero fields");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !adv)
      else $error("pipeline advanced into a held output");

endmodule

>>> design/delay_coarse_fine_converter.sv
// channel | dir | handshake     | payload
// req     | in  | valid / ready | command, delay_in_qns, coarse_in, fine_in
// rsp     | out | valid / ready | coarse_out, fine_out, delay_out_qns, overload
// csr     | in  | csr_we        | csr_index, csr_wdata
// one item per cycle while no rsp item is held; 54 divider cells, one
// quotient bit each, then select, multiply and saturate stages
// reset is synchronous and clears the valid bits and the csr registers
// a held rsp item stalls the whole chain; req.ready drops in the same cycle
module delay_coarse_fine_converter #(
   parameter int COARSE_BITS = dcf_pkg::COARSE_BITS_DEF,
   parameter int FINE_BITS   = dcf_pkg::FINE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [dcf_pkg::CSR_W-1:0]  csr_wdata,
   dcf_req_if.sink                    req,
   dcf_rsp_if.source                  rsp
);
   import dcf_pkg::*;

   logic                split_mode_ff;
   logic [1:0]          clock_source_ff;
   logic [1:0]          div_exp_ff;
   logic [PERIOD_W-1:0] ext_period_ff;

   logic [PERIOD_W-1:0] period_eff, base;
   logic [QUANT_W-1:0]  quantum;
   logic                adv;

   ctl_type                ctl_s    [0:NUM_W];
   logic [NUM_W-1:0]       num_s    [0:NUM_W];
   logic [DIV_W-1:0]       dvs_s    [0:NUM_W];
   logic [DIV_W-1:0]       rem_s    [0:NUM_W];
   logic [COARSE_BITS-1:0] quo_s    [0:NUM_W];
   logic                   sat_s    [0:NUM_W];
   logic [COARSE_BITS-1:0] code_c_s [0:NUM_W];
   logic [FINE_BITS-1:0]   code_f_s [0:NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         split_mode_ff   <= 1'b0;
         clock_source_ff <= '0;
         div_exp_ff      <= '0;
         ext_period_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SPLIT_MODE:   split_mode_ff   <= csr_wdata[0];
            CSR_CLOCK_SOURCE: clock_source_ff <= csr_wdata[1:0];
            CSR_DIV_EXP:      div_exp_ff      <= csr_wdata[1:0];
            CSR_EXT_PERIOD:   ext_period_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      period_eff = (ext_period_ff > MAX_EXT_PERIOD) ? MAX_EXT_PERIOD : ext_period_ff;
      base       = (clock_source_ff == SRC_EXTERNAL) ? period_eff : INT_PERIOD_QNS;
      quantum    = QUANT_W'(base) << div_exp_ff;

      ctl_s[0].valid       = req.valid;
      ctl_s[0].decode      = req.command == CMD_DECODE;
      ctl_s[0].coarse_only = split_mode_ff;
      ctl_s[0].rounding    = split_mode_ff && req.command == CMD_ENCODE;
      ctl_s[0].ovl         = quantum == '0;
      // rounded quotient is (2d + q) / 2q
      if (ctl_s[0].rounding) begin
         num_s[0] = {1'b0, req.delay_in_qns, 1'b0} + NUM_W'(quantum);
         dvs_s[0] = {quantum, 1'b0};
      end else begin
         num_s[0] = NUM_W'(req.delay_in_qns);
         dvs_s[0] = {1'b0, quantum};
      end
      rem_s[0]    = '0;
      quo_s[0]    = '0;
      sat_s[0]    = 1'b0;
      code_c_s[0] = req.coarse_in;
      code_f_s[0] = req.fine_in;
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_cell
      dcf_cell #(.COARSE_BITS(COARSE_BITS), .FINE_BITS(FINE_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_i    (ctl_s[k]),
         .num_i    (num_s[k]),
         .dvs_i    (dvs_s[k]),
         .rem_i    (rem_s[k]),
         .quo_i    (quo_s[k]),
         .sat_i    (sat_s[k]),
         .code_c_i (code_c_s[k]),
         .code_f_i (code_f_s[k]),
         .ctl_o    (ctl_s[k+1]),
         .num_o    (num_s[k+1]),
         .dvs_o    (dvs_s[k+1]),
         .rem_o    (rem_s[k+1]),
         .quo_o    (quo_s[k+1]),
         .sat_o    (sat_s[k+1]),
         .code_c_o (code_c_s[k+1]),
         .code_f_o (code_f_s[k+1])
      );
   end

   dcf_tail #(.COARSE_BITS(COARSE_BITS), .FINE_BITS(FINE_BITS)) u_tail (
      .clock      (clock),
      .reset      (reset),
      .rsp_ready  (rsp.ready),
      .adv        (adv),
      .ctl_i      (ctl_s[NUM_W]),
      .dvs_i      (dvs_s[NUM_W]),
      .rem_i      (rem_s[NUM_W]),
      .quo_i      (quo_s[NUM_W]),
      .sat_i      (sat_s[NUM_W]),
      .code_c_i   (code_c_s[NUM_W]),
      .code_f_i   (code_f_s[NUM_W]),
      .out_valid  (rsp.valid),
      .coarse_out (rsp.coarse_out),
      .fine_out   (rsp.fine_out),
      .delay_out  (rsp.delay_out_qns),
      .overload   (rsp.overload)
   );

   assign req.ready = adv;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty output");

   a_num_unused_zero: assert property (@(posedge clock) disable iff (reset)
      ctl_s[NUM_W].valid |-> num_s[NUM_W] == '0)
      else $error("numerator bits left after last cell");

endmodule
